@@ rtl/mblts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mblts_pkg
// Types and constants shared by the memory bus line test sequencer.
// ----------------------------------------------------------------------------
package mblts_pkg;

  localparam int unsigned SEG_W      = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LINES_W    = 5;
  localparam int unsigned LINE_IDX_W = 4;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TAIL_N     = 3;
  localparam int unsigned TAIL_IDX_W = 2;

  localparam logic [DATA_W-1:0] PAT_A = 8'hAA;
  localparam logic [DATA_W-1:0] PAT_B = 8'h55;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES   = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_REPORT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DATA = 3'd1,
    PH_PAT  = 3'd2,
    PH_ANTI = 3'd3
  } phase_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } rec_t;

  // one accepted beat expands to clr_cnt clears followed by tail_cnt records
  typedef struct packed {
    logic [LINES_W-1:0]    clr_cnt;
    logic [TAIL_IDX_W-1:0] tail_cnt;
    rec_t [TAIL_N-1:0]     tail;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/mblts_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mblts_cmd_if / mblts_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mblts_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] read_data;

  modport source (output valid, kind, read_data, input ready);
  modport sink (input valid, kind, read_data, output ready);
endinterface

interface mblts_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] access_segment;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  data_fault_mask;
  logic [15:0] address_fault_mask;
  logic        fatal;
  logic        last;

  modport source (
    output valid, op, access_segment, address, write_data, data_fault_mask,
           address_fault_mask, fatal, last,
    input  ready
  );
  modport sink (
    input  valid, op, access_segment, address, write_data, data_fault_mask,
           address_fault_mask, fatal, last,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/mblts_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mblts_emit
// Holds the expanded job of one command beat and hands out one result beat
// per cycle through an output register while the res channel is not stalled.
// ----------------------------------------------------------------------------
module mblts_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  mblts_pkg::job_t                  job,
  input  logic [mblts_pkg::SEG_W-1:0]      segment,
  input  logic [mblts_pkg::DATA_W-1:0]     data_faults,
  input  logic [mblts_pkg::ADDR_W-1:0]     address_faults,
  output logic                             busy,
  mblts_res_if.source                      res
);

  logic [mblts_pkg::LINES_W-1:0]    clr_left;
  logic [mblts_pkg::LINE_IDX_W-1:0] clr_idx;
  mblts_pkg::rec_t                  tail [mblts_pkg::TAIL_N];
  logic [mblts_pkg::TAIL_IDX_W-1:0] tail_cnt;
  logic [mblts_pkg::TAIL_IDX_W-1:0] tail_idx;

  mblts_pkg::rec_t cur;
  logic            cur_last;
  logic            advance;
  logic            emit;

  logic                            o_valid;
  mblts_pkg::rec_t                 o_rec;
  logic [mblts_pkg::SEG_W-1:0]     o_seg;
  logic [mblts_pkg::DATA_W-1:0]    o_dmask;
  logic [mblts_pkg::ADDR_W-1:0]    o_amask;
  logic                            o_fatal;
  logic                            o_last;

  assign advance = !o_valid || res.ready;
  assign emit    = busy && advance;

  always_comb begin
    if (clr_left != '0) begin
      cur.op         = mblts_pkg::OP_WRITE;
      cur.address    = mblts_pkg::ADDR_W'(1) << clr_idx;
      cur.write_data = '0;
      cur_last       = 1'b0;
    end else begin
      cur      = tail[tail_idx];
      cur_last = (tail_idx == (tail_cnt - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      clr_left <= '0;
      clr_idx  <= '0;
      tail_cnt <= '0;
      tail_idx <= '0;
    end else if (load) begin
      busy     <= 1'b1;
      clr_left <= job.clr_cnt;
      clr_idx  <= '0;
      tail_cnt <= job.tail_cnt;
      tail_idx <= '0;
    end else if (emit) begin
      if (clr_left != '0) begin
        clr_left <= clr_left - 1'b1;
        clr_idx  <= clr_idx + 1'b1;
      end else begin
        tail_idx <= tail_idx + 1'b1;
        if (cur_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < mblts_pkg::TAIL_N; i++) begin
        tail[i] <= job.tail[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_rec  <= cur;
      o_seg  <= segment;
      o_last <= cur_last;
      if (cur.op == mblts_pkg::OP_REPORT) begin
        o_dmask <= data_faults;
        o_amask <= address_faults;
        o_fatal <= (data_faults != '0) && (address_faults != '0);
      end else begin
        o_dmask <= '0;
        o_amask <= '0;
        o_fatal <= 1'b0;
      end
    end
  end

  assign res.valid              = o_valid;
  assign res.op                 = o_rec.op;
  assign res.access_segment     = o_seg;
  assign res.address            = o_rec.address;
  assign res.write_data         = o_rec.write_data;
  assign res.data_fault_mask    = o_dmask;
  assign res.address_fault_mask = o_amask;
  assign res.fatal              = o_fatal;
  assign res.last               = o_last;

endmodule
`default_nettype wire

@@ rtl/memory_bus_line_test_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_bus_line_test_sequencer
// Walking-ones data bus test and address bus aliasing test on a byte memory,
// driven by start commands and returned read bytes.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    kind, read_data
//   res      out  valid/ready    op, access_segment, address, write_data,
//                                data_fault_mask, address_fault_mask, fatal, last
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// a command beat updates the test state in the cycle it is taken and expands
// into 0 to 19 result beats, one per cycle through the output register while
// res is not stalled; the next command is taken as soon as the last result of
// the beat sits in the output register
// a stalled res channel holds the output register and stops the expansion
// reset is synchronous; the test returns to idle with both masks cleared
// ----------------------------------------------------------------------------
module memory_bus_line_test_sequencer #(
  parameter int unsigned MAX_ADDRESS_LINES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  mblts_cmd_if.sink                             cmd,
  mblts_res_if.source                           res,
  input  logic                                  cfg_we,
  input  logic [mblts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mblts_pkg::SEG_W-1:0]           cfg_data
);

  logic [mblts_pkg::SEG_W-1:0]      memory_segment;
  logic [mblts_pkg::LINES_W-1:0]    address_lines;

  mblts_pkg::phase_t                phase, phase_next;
  logic [mblts_pkg::LINE_IDX_W-1:0] line_index, line_index_next;
  logic [mblts_pkg::DATA_W-1:0]     data_faults, data_faults_next;
  logic [mblts_pkg::ADDR_W-1:0]     address_faults, address_faults_next;

  logic                             busy;
  logic                             accept;
  logic                             load;
  mblts_pkg::job_t                  job;

  logic [mblts_pkg::LINES_W-1:0]    n_lines;
  logic [mblts_pkg::BIT_IDX_W-1:0]  bit_idx;
  logic [mblts_pkg::DATA_W-1:0]     expect_bit;
  logic [mblts_pkg::LINES_W-1:0]    line_inc;
  logic                             more_lines;
  logic [mblts_pkg::DATA_W-1:0]     pat;

  assign cmd.ready = !busy && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign load      = accept && (job.tail_cnt != '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_segment <= 16'd640;
      address_lines  <= 5'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mblts_pkg::CFG_SEGMENT: memory_segment <= cfg_data;
        mblts_pkg::CFG_LINES:   address_lines  <= cfg_data[mblts_pkg::LINES_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_lines = (address_lines > mblts_pkg::LINES_W'(MAX_ADDRESS_LINES))
                 ? mblts_pkg::LINES_W'(MAX_ADDRESS_LINES) : address_lines;
  assign bit_idx    = line_index[mblts_pkg::BIT_IDX_W-1:0];
  assign expect_bit = mblts_pkg::DATA_W'(1) << bit_idx;
  assign line_inc   = {1'b0, line_index} + 1'b1;
  assign more_lines = line_inc < n_lines;
  assign pat        = (phase == mblts_pkg::PH_PAT) ? mblts_pkg::PAT_A : mblts_pkg::PAT_B;

  // next state
  always_comb begin
    phase_next          = phase;
    line_index_next     = line_index;
    data_faults_next    = data_faults;
    address_faults_next = address_faults;
    if (cmd.kind == mblts_pkg::KIND_START) begin
      phase_next          = mblts_pkg::PH_DATA;
      line_index_next     = '0;
      data_faults_next    = '0;
      address_faults_next = '0;
    end else begin
      unique case (phase)
        mblts_pkg::PH_DATA: begin
          if (cmd.read_data != expect_bit) begin
            data_faults_next = data_faults | expect_bit;
          end
          if (bit_idx != '1) begin
            line_index_next = line_index + 1'b1;
          end else begin
            line_index_next = '0;
            phase_next      = (n_lines != '0) ? mblts_pkg::PH_PAT : mblts_pkg::PH_IDLE;
          end
        end
        mblts_pkg::PH_PAT, mblts_pkg::PH_ANTI: begin
          if (cmd.read_data == pat) begin
            address_faults_next = address_faults | (mblts_pkg::ADDR_W'(1) << line_index);
          end
          if (more_lines) begin
            line_index_next = line_inc[mblts_pkg::LINE_IDX_W-1:0];
          end else begin
            line_index_next = '0;
            if (phase == mblts_pkg::PH_PAT && n_lines != '0) begin
              phase_next = mblts_pkg::PH_ANTI;
            end else begin
              phase_next = mblts_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result job
  always_comb begin
    job          = '0;
    job.tail[0].op = mblts_pkg::OP_WRITE;
    job.tail[1].op = mblts_pkg::OP_READ;
    if (cmd.kind == mblts_pkg::KIND_START) begin
      job.tail_cnt           = 2'd2;
      job.tail[0].write_data = mblts_pkg::DATA_W'(1);
    end else begin
      unique case (phase)
        mblts_pkg::PH_DATA: begin
          if (bit_idx != '1) begin
            job.tail_cnt           = 2'd2;
            job.tail[0].write_data = mblts_pkg::DATA_W'(1) << (bit_idx + 1'b1);
          end else begin
            job.clr_cnt            = n_lines;
            job.tail_cnt           = 2'd3;
            job.tail[0].write_data = mblts_pkg::PAT_A;
            job.tail[1].op         = mblts_pkg::OP_WRITE;
            if (n_lines != '0) begin
              job.tail[1].write_data = mblts_pkg::PAT_A;
              job.tail[2].op         = mblts_pkg::OP_READ;
              job.tail[2].address    = mblts_pkg::ADDR_W'(1);
            end else begin
              job.tail[1].write_data = mblts_pkg::PAT_B;
              job.tail[2].op         = mblts_pkg::OP_REPORT;
            end
          end
        end
        mblts_pkg::PH_PAT, mblts_pkg::PH_ANTI: begin
          if (more_lines) begin
            job.tail_cnt           = 2'd2;
            job.tail[0].write_data = pat;
            job.tail[1].address    = mblts_pkg::ADDR_W'(1) << line_inc[mblts_pkg::LINE_IDX_W-1:0];
          end else if (phase == mblts_pkg::PH_PAT && n_lines != '0) begin
            job.tail_cnt           = 2'd3;
            job.tail[0].write_data = mblts_pkg::PAT_B;
            job.tail[1].op         = mblts_pkg::OP_WRITE;
            job.tail[1].write_data = mblts_pkg::PAT_B;
            job.tail[2].op         = mblts_pkg::OP_READ;
            job.tail[2].address    = mblts_pkg::ADDR_W'(1);
          end else if (phase == mblts_pkg::PH_PAT) begin
            job.tail_cnt           = 2'd2;
            job.tail[0].write_data = mblts_pkg::PAT_B;
            job.tail[1].op         = mblts_pkg::OP_REPORT;
          end else begin
            job.tail_cnt   = 2'd1;
            job.tail[0].op = mblts_pkg::OP_REPORT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mblts_pkg::PH_IDLE;
      line_index     <= '0;
      data_faults    <= '0;
      address_faults <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      line_index     <= line_index_next;
      data_faults    <= data_faults_next;
      address_faults <= address_faults_next;
    end
  end

  mblts_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .job            (job),
    .segment        (memory_segment),
    .data_faults    (data_faults),
    .address_faults (address_faults),
    .busy           (busy),
    .res            (res)
  );

`ifndef SYNTHESIS
  a_report_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.op == mblts_pkg::OP_REPORT |-> res.last)
    else $error("report beat without last");

  a_start_enters_data: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.kind == mblts_pkg::KIND_START |=> phase == mblts_pkg::PH_DATA && busy)
    else $error("start did not begin the data bus test");

  a_fatal_matches_masks: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.op == mblts_pkg::OP_REPORT
      |-> res.fatal == (res.data_fault_mask != '0 && res.address_fault_mask != '0))
    else $error("fatal flag disagrees with fault masks");

  a_request_masks_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.op != mblts_pkg::OP_REPORT
      |-> !res.fatal && res.data_fault_mask == '0 && res.address_fault_mask == '0)
    else $error("request beat carries report fields");
`endif

endmodule
`default_nettype wire
